// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SRS_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SRS_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/srs_pkg.sv -----
// types, constants and microcode table of the stripe request splitter
package srs_pkg;

  localparam int BLOCK_SHIFT       = 10;
  localparam int MAX_DISKS         = 8;
  localparam int MAX_REQUEST_BYTES = 65536;
  localparam int MAX_SEGMENTS      = 33;
  localparam int MIN_STRIPE_SHIFT  = 11;
  localparam int MAX_STRIPE_SHIFT  = 20;

  localparam int ADDR_W    = 32;
  localparam int BLOCK_W   = 22;
  localparam int LEN_W     = 17;
  localparam int BUF_W     = 16;
  localparam int DISK_W    = 3;
  localparam int DCOUNT_W  = 4;
  localparam int SHIFT_W   = 5;
  localparam int STRIPE_W  = ADDR_W - MIN_STRIPE_SHIFT;
  localparam int INOFF_W   = MAX_STRIPE_SHIFT;
  localparam int REMSTR_W  = MAX_STRIPE_SHIFT + 1;
  localparam int DIVCNT_W  = $clog2(STRIPE_W);
  localparam int SEG_W     = $clog2(MAX_SEGMENTS);
  localparam int REGIDX_W  = 2;
  localparam int PC_W      = 3;

  localparam logic [REGIDX_W-1:0] REG_DISK_COUNT   = 2'd0;
  localparam logic [REGIDX_W-1:0] REG_STRIPE_SHIFT = 2'd1;
  localparam logic [REGIDX_W-1:0] REG_VOLUME_START = 2'd2;

  typedef struct packed {
    logic [BLOCK_W-1:0] start_block;
    logic [LEN_W-1:0]   length_bytes;
  } in_beat_t;

  typedef struct packed {
    logic [DISK_W-1:0]  disk_index;
    logic [BLOCK_W-1:0] disk_block;
    logic [LEN_W-1:0]   segment_bytes;
    logic [BUF_W-1:0]   buffer_offset;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic [REGIDX_W-1:0] reg_index;
    logic [ADDR_W-1:0]   wdata;
  } cfg_beat_t;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_IDLE  = 3'd0;
  localparam pc_t PC_CHK   = 3'd1;
  localparam pc_t PC_DIV   = 3'd2;
  localparam pc_t PC_SETUP = 3'd3;
  localparam pc_t PC_EMIT  = 3'd4;
  localparam pc_t PC_DONE  = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_SETUP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_LEN_ZERO,
    C_DIV_BUSY,
    C_SEG_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic in_fire;
    logic len_zero;
    logic div_busy;
    logic seg_more;
  } seq_flags_t;

  // jump to target when cond holds, else fall through to the next step
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_IDLE};
    case (pc)
      PC_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_IN,    target: PC_IDLE};
      PC_CHK:   w = '{op: OP_NOP,   cond: C_LEN_ZERO, target: PC_IDLE};
      PC_DIV:   w = '{op: OP_DIV,   cond: C_DIV_BUSY, target: PC_DIV};
      PC_SETUP: w = '{op: OP_SETUP, cond: C_NEVER,    target: PC_IDLE};
      PC_EMIT:  w = '{op: OP_EMIT,  cond: C_SEG_MORE, target: PC_EMIT};
      PC_DONE:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: PC_IDLE};
      default:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/srs_chan_if.sv -----
// valid/ready channel carrying one payload beat
interface srs_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/srs_seq.sv -----
// microcode sequencer: step counter, control rom and jump logic
module srs_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  srs_pkg::seq_flags_t flags,
  output srs_pkg::ucode_t     word
);

  srs_pkg::pc_t pc_r;
  srs_pkg::pc_t pc_nxt;
  logic         take;

  assign word = srs_pkg::ucode_rom(pc_r);

  always_comb begin
    case (word.cond)
      srs_pkg::C_NEVER:    take = 1'b0;
      srs_pkg::C_ALWAYS:   take = 1'b1;
      srs_pkg::C_NO_IN:    take = !flags.in_fire;
      srs_pkg::C_LEN_ZERO: take = flags.len_zero;
      srs_pkg::C_DIV_BUSY: take = flags.div_busy;
      srs_pkg::C_SEG_MORE: take = flags.seg_more;
      default:             take = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt = take ? word.target : pc_r + srs_pkg::pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= srs_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ----- rtl/core/stripe_request_splitter_top.sv -----
// stripe request splitter: maps a volume read onto per-disk stripe segments
//
//  channel  dir  beat                                   handshake
//  in_if    in   start_block, length_bytes              valid/ready
//  out_if   out  disk_index, disk_block, segment_bytes,  valid/ready
//                buffer_offset, last
//  cfg_if   in   reg_index, wdata                       valid/ready, always ready
//
// a request steps through accept, length check, divide, setup and one emit per segment;
// the stripe / disk_count divider is bit-serial, one bit a cycle
// a zero-length request produces nothing
// the result register lets the next request in while the final segment waits
// synchronous active-low reset restores disk_count 1, stripe_shift 16, volume_start 0
// out stalls hold the sequencer on the emit step
module stripe_request_splitter_top (
  input  logic              clk,
  input  logic              rst_n,
  srs_chan_if.sink          in_if,
  srs_chan_if.source        out_if,
  srs_chan_if.sink          cfg_if
);

  // configuration
  logic [srs_pkg::DCOUNT_W-1:0] disk_count_r;
  logic [srs_pkg::SHIFT_W-1:0]  stripe_shift_r;
  logic [srs_pkg::ADDR_W-1:0]   volume_start_r;
  logic [srs_pkg::DCOUNT_W-1:0] eff_disks;
  logic [srs_pkg::SHIFT_W-1:0]  eff_shift;

  // datapath
  logic [srs_pkg::ADDR_W-1:0]   offset_r, offset_nxt;
  logic [srs_pkg::LEN_W-1:0]    length_r, length_nxt;
  logic [srs_pkg::BUF_W-1:0]    bufpos_r, bufpos_nxt;
  logic [srs_pkg::SEG_W-1:0]    seg_n_r, seg_n_nxt;
  logic [srs_pkg::STRIPE_W-1:0] quot_r, quot_nxt;
  logic [srs_pkg::DISK_W-1:0]   rem_r, rem_nxt;
  logic [srs_pkg::DIVCNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [srs_pkg::ADDR_W-1:0]   base_r, base_nxt;
  logic [srs_pkg::DISK_W-1:0]   disk_r, disk_nxt;
  logic                         out_valid_r, out_valid_nxt;
  srs_pkg::out_beat_t           out_r, out_nxt;

  srs_pkg::ucode_t     word;
  srs_pkg::seq_flags_t flags;

  logic                         in_fire;
  logic                         emit_go;
  logic [srs_pkg::ADDR_W-1:0]   offset_ld;
  logic [srs_pkg::LEN_W-1:0]    length_ld;
  logic [srs_pkg::DCOUNT_W-1:0] div_trial;
  logic [srs_pkg::ADDR_W-1:0]   smask;
  logic [srs_pkg::ADDR_W-1:0]   stripe_bytes;
  logic [srs_pkg::INOFF_W-1:0]  in_off;
  logic [srs_pkg::REMSTR_W-1:0] rem_stripe;
  logic [srs_pkg::LEN_W-1:0]    count;
  logic [srs_pkg::ADDR_W-1:0]   addr;
  logic [srs_pkg::ADDR_W-1:0]   offset_adv;
  logic                         seg_last;

  srs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .word  (word)
  );

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disk_count_r   <= srs_pkg::DCOUNT_W'(1);
      stripe_shift_r <= srs_pkg::SHIFT_W'(16);
      volume_start_r <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.payload.reg_index)
        srs_pkg::REG_DISK_COUNT:
          disk_count_r <= cfg_if.payload.wdata[srs_pkg::DCOUNT_W-1:0];
        srs_pkg::REG_STRIPE_SHIFT:
          stripe_shift_r <= cfg_if.payload.wdata[srs_pkg::SHIFT_W-1:0];
        srs_pkg::REG_VOLUME_START:
          volume_start_r <= cfg_if.payload.wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (disk_count_r == '0) begin
      eff_disks = srs_pkg::DCOUNT_W'(1);
    end else if (disk_count_r > srs_pkg::DCOUNT_W'(srs_pkg::MAX_DISKS)) begin
      eff_disks = srs_pkg::DCOUNT_W'(srs_pkg::MAX_DISKS);
    end else begin
      eff_disks = disk_count_r;
    end
    if (stripe_shift_r < srs_pkg::SHIFT_W'(srs_pkg::MIN_STRIPE_SHIFT)) begin
      eff_shift = srs_pkg::SHIFT_W'(srs_pkg::MIN_STRIPE_SHIFT);
    end else if (stripe_shift_r > srs_pkg::SHIFT_W'(srs_pkg::MAX_STRIPE_SHIFT)) begin
      eff_shift = srs_pkg::SHIFT_W'(srs_pkg::MAX_STRIPE_SHIFT);
    end else begin
      eff_shift = stripe_shift_r;
    end
  end

  assign in_if.ready  = (word.op == srs_pkg::OP_LOAD);
  assign in_fire      = in_if.valid && in_if.ready;
  assign emit_go      = (word.op == srs_pkg::OP_EMIT) && (!out_valid_r || out_if.ready);

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_r;

  always_comb begin
    offset_ld = srs_pkg::ADDR_W'(in_if.payload.start_block) << srs_pkg::BLOCK_SHIFT;
    if (in_if.payload.length_bytes > srs_pkg::LEN_W'(srs_pkg::MAX_REQUEST_BYTES)) begin
      length_ld = srs_pkg::LEN_W'(srs_pkg::MAX_REQUEST_BYTES);
    end else begin
      length_ld = in_if.payload.length_bytes;
    end
  end

  // segment arithmetic
  always_comb begin
    smask        = (srs_pkg::ADDR_W'(1) << eff_shift) - srs_pkg::ADDR_W'(1);
    stripe_bytes = srs_pkg::ADDR_W'(1) << eff_shift;
    in_off       = srs_pkg::INOFF_W'(offset_r & smask);
    rem_stripe   = (srs_pkg::REMSTR_W'(1) << eff_shift) - srs_pkg::REMSTR_W'(in_off);
    if (srs_pkg::REMSTR_W'(length_r) > rem_stripe) begin
      count = srs_pkg::LEN_W'(rem_stripe);
    end else begin
      count = length_r;
    end
    addr       = base_r + srs_pkg::ADDR_W'(in_off);
    offset_adv = offset_r + srs_pkg::ADDR_W'(count);
    seg_last   = (count == length_r)
              || (seg_n_r == srs_pkg::SEG_W'(srs_pkg::MAX_SEGMENTS - 1));
  end

  // one restoring step of stripe / disk count
  assign div_trial = {rem_r, quot_r[srs_pkg::STRIPE_W-1]};

  always_comb begin
    flags.in_fire  = in_fire;
    flags.len_zero = (length_r == '0);
    flags.div_busy = (div_cnt_r != srs_pkg::DIVCNT_W'(srs_pkg::STRIPE_W - 1));
    flags.seg_more = !(emit_go && seg_last);
  end

  always_comb begin
    offset_nxt    = offset_r;
    length_nxt    = length_r;
    bufpos_nxt    = bufpos_r;
    seg_n_nxt     = seg_n_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    base_nxt      = base_r;
    disk_nxt      = disk_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_if.ready;

    case (word.op)
      srs_pkg::OP_LOAD: begin
        if (in_fire) begin
          offset_nxt  = offset_ld;
          length_nxt  = length_ld;
          bufpos_nxt  = '0;
          seg_n_nxt   = '0;
          quot_nxt    = srs_pkg::STRIPE_W'(offset_ld >> eff_shift);
          rem_nxt     = '0;
          div_cnt_nxt = '0;
        end
      end
      srs_pkg::OP_DIV: begin
        if (div_trial >= eff_disks) begin
          rem_nxt  = srs_pkg::DISK_W'(div_trial - eff_disks);
          quot_nxt = {quot_r[srs_pkg::STRIPE_W-2:0], 1'b1};
        end else begin
          rem_nxt  = div_trial[srs_pkg::DISK_W-1:0];
          quot_nxt = {quot_r[srs_pkg::STRIPE_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + srs_pkg::DIVCNT_W'(1);
      end
      srs_pkg::OP_SETUP: begin
        base_nxt = volume_start_r + (srs_pkg::ADDR_W'(quot_r) << eff_shift);
        disk_nxt = rem_r;
      end
      srs_pkg::OP_EMIT: begin
        if (emit_go) begin
          out_valid_nxt         = 1'b1;
          out_nxt.disk_index    = disk_r;
          out_nxt.disk_block    = addr[srs_pkg::ADDR_W-1:srs_pkg::BLOCK_SHIFT];
          out_nxt.segment_bytes = count;
          out_nxt.buffer_offset = bufpos_r;
          out_nxt.last          = seg_last;
          offset_nxt            = offset_adv;
          length_nxt            = length_r - count;
          bufpos_nxt            = bufpos_r + srs_pkg::BUF_W'(count);
          seg_n_nxt             = seg_n_r + srs_pkg::SEG_W'(1);
          // wrapping past the top of the address space restarts at stripe zero
          if (offset_adv == '0) begin
            disk_nxt = '0;
            base_nxt = volume_start_r;
          end else if ({1'b0, disk_r} + srs_pkg::DCOUNT_W'(1) == eff_disks) begin
            disk_nxt = '0;
            base_nxt = base_r + stripe_bytes;
          end else begin
            disk_nxt = disk_r + srs_pkg::DISK_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r  <= offset_nxt;
    length_r  <= length_nxt;
    bufpos_r  <= bufpos_nxt;
    seg_n_r   <= seg_n_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    div_cnt_r <= div_cnt_nxt;
    base_r    <= base_nxt;
    disk_r    <= disk_nxt;
    out_r     <= out_nxt;
  end

endmodule

// ----- rtl/core/srs_checker.sv -----
// port-level checks for the stripe request splitter, bound to the top level
`include "assert_macros.svh"

module srs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input srs_pkg::out_beat_t out_payload
);

  // a stalled result beat stays put
  `SRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload), "out beat changed while stalled")

  // every segment carries at least one byte
  `SRS_ASSERT_NOW(a_seg_nonzero, clk, rst_n, out_valid, out_payload.segment_bytes != '0, "empty segment")

  // the sequencer leaves the accept step right after a request beat
  `SRS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted two requests back to back")

  // no new request while a request is still being split
  `SRS_ASSERT_NOW(a_no_accept_mid_request, clk, rst_n, out_valid && !out_payload.last, !in_ready, "request accepted before last segment")

endmodule

bind stripe_request_splitter_top srs_checker u_srs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_payload (out_if.payload)
);

// ----- tb/stripe_request_splitter_top_tb.sv -----
`timescale 1ns / 100ps
// testbench for the stripe request splitter: directed rows, random phases, segment scoreboard
module stripe_request_splitter_top_tb;

  localparam int ITEMS_PER_PHASE   = 20;
  localparam int RANDOM_PHASES     = 8;
  localparam int PRESSURE_PHASE    = 6;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int DRAIN_CYCLES      = 40;

  typedef enum logic [1:0] {
    ROW_REQ,
    ROW_REQ_GOLDEN,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t                    kind;
    logic [srs_pkg::REGIDX_W-1:0] reg_index;
    logic [srs_pkg::ADDR_W-1:0]   wdata;
    srs_pkg::in_beat_t            req;
    srs_pkg::out_beat_t           golden;
  } stim_row_t;

  typedef struct {
    bit                 golden;
    srs_pkg::out_beat_t beat;
  } req_note_t;

  logic clk;
  logic rst_n;

  srs_chan_if #(.payload_t(srs_pkg::in_beat_t))  in_ch ();
  srs_chan_if #(.payload_t(srs_pkg::out_beat_t)) out_ch ();
  srs_chan_if #(.payload_t(srs_pkg::cfg_beat_t)) cfg_ch ();

  stripe_request_splitter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // register shadow, updated on each accepted config beat
  logic [srs_pkg::DCOUNT_W-1:0] disk_count_q;
  logic [srs_pkg::SHIFT_W-1:0]  stripe_shift_q;
  logic [srs_pkg::ADDR_W-1:0]   volume_start_q;

  srs_pkg::out_beat_t expected_segments[$];
  req_note_t          request_notes[$];
  stim_row_t          directed_rows[$];
  int                 mismatch_count;
  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 stall_requests;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // one segment per stripe crossed, with the register clamps applied
  function automatic void predict_segments(input srs_pkg::in_beat_t req);
    logic [srs_pkg::ADDR_W-1:0] offset, remaining, bufpos, first, lastb, tail, count, addr;
    logic [srs_pkg::ADDR_W-1:0] smask;
    logic [srs_pkg::ADDR_W-1:0] disks;
    int                         shift;
    int                         n;
    srs_pkg::out_beat_t         seg;
    disks = 32'(disk_count_q);
    if (disks == 0) disks = 1;
    if (disks > srs_pkg::MAX_DISKS) disks = srs_pkg::MAX_DISKS;
    shift = int'(stripe_shift_q);
    if (shift < srs_pkg::MIN_STRIPE_SHIFT) shift = srs_pkg::MIN_STRIPE_SHIFT;
    if (shift > srs_pkg::MAX_STRIPE_SHIFT) shift = srs_pkg::MAX_STRIPE_SHIFT;
    smask = (32'd1 << shift) - 32'd1;
    offset = {req.start_block, {srs_pkg::BLOCK_SHIFT{1'b0}}};
    remaining = 32'(req.length_bytes);
    if (remaining > srs_pkg::MAX_REQUEST_BYTES) remaining = srs_pkg::MAX_REQUEST_BYTES;
    bufpos = '0;
    n = 0;
    while (remaining != 0 && n < srs_pkg::MAX_SEGMENTS) begin
      tail = offset + remaining - 32'd1;
      first = offset >> shift;
      lastb = tail >> shift;
      // a segment stops at the stripe end, which also covers the 32-bit wrap
      if (first != lastb) count = ((first + 32'd1) << shift) - offset;
      else count = remaining;
      addr = volume_start_q + ((first / disks) << shift) + (offset & smask);
      seg.disk_index    = srs_pkg::DISK_W'(first % disks);
      seg.disk_block    = srs_pkg::BLOCK_W'(addr >> srs_pkg::BLOCK_SHIFT);
      seg.segment_bytes = srs_pkg::LEN_W'(count);
      seg.buffer_offset = srs_pkg::BUF_W'(bufpos);
      seg.last          = 1'b0;
      expected_segments.push_back(seg);
      offset = offset + count;
      bufpos = bufpos + count;
      remaining = remaining - count;
      n++;
    end
    if (n > 0) expected_segments[expected_segments.size() - 1].last = 1'b1;
  endfunction

  task automatic check_segment(input srs_pkg::out_beat_t got);
    srs_pkg::out_beat_t exp_seg;
    if (expected_segments.size() == 0) begin
      flag_mismatch($sformatf("segment with nothing expected: %p", got));
      return;
    end
    exp_seg = expected_segments.pop_front();
    if (got.disk_index !== exp_seg.disk_index)
      flag_mismatch($sformatf("disk_index %0d, expected %0d",
                              got.disk_index, exp_seg.disk_index));
    if (got.disk_block !== exp_seg.disk_block)
      flag_mismatch($sformatf("disk_block 0x%0h, expected 0x%0h",
                              got.disk_block, exp_seg.disk_block));
    if (got.segment_bytes !== exp_seg.segment_bytes)
      flag_mismatch($sformatf("segment_bytes %0d, expected %0d",
                              got.segment_bytes, exp_seg.segment_bytes));
    if (got.buffer_offset !== exp_seg.buffer_offset)
      flag_mismatch($sformatf("buffer_offset %0d, expected %0d",
                              got.buffer_offset, exp_seg.buffer_offset));
    if (got.last !== exp_seg.last)
      flag_mismatch($sformatf("last %0b, expected %0b", got.last, exp_seg.last));
  endtask

  // output beats are checked before a request accepted on the same edge is predicted
  always @(posedge clk) begin
    req_note_t note;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_segment(out_ch.payload);
      if (in_ch.valid && in_ch.ready) begin
        note = request_notes.pop_front();
        if (note.golden) expected_segments.push_back(note.beat);
        else predict_segments(in_ch.payload);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.payload.reg_index)
          srs_pkg::REG_DISK_COUNT:
            disk_count_q = cfg_ch.payload.wdata[srs_pkg::DCOUNT_W-1:0];
          srs_pkg::REG_STRIPE_SHIFT:
            stripe_shift_q = cfg_ch.payload.wdata[srs_pkg::SHIFT_W-1:0];
          srs_pkg::REG_VOLUME_START:
            volume_start_q = cfg_ch.payload.wdata;
          default: ;
        endcase
      end
    end else begin
      disk_count_q   = 4'd1;
      stripe_shift_q = 5'd16;
      volume_start_q = '0;
    end
  end

  // receiver: random backpressure, plus a long hold-off when asked
  initial begin
    int hold_left;
    int stalls_seen;
    hold_left = 0;
    stalls_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_requests != stalls_seen) begin
        stalls_seen = stall_requests;
        hold_left = LONG_STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_request(input srs_pkg::in_beat_t req, input bit golden,
                              input srs_pkg::out_beat_t beat);
    req_note_t note;
    note.golden = golden;
    note.beat = beat;
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    request_notes.push_back(note);
    in_ch.valid <= 1'b1;
    in_ch.payload <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_register(input logic [srs_pkg::REGIDX_W-1:0] idx,
                                input logic [srs_pkg::ADDR_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= '{reg_index: idx, wdata: data};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // zero-length requests leave no trace in the queue, so give the block time to settle
  task automatic wait_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic stim_row_t req_row(input int start, input int len);
    stim_row_t r;
    r = '{kind: ROW_REQ, reg_index: '0, wdata: '0, req: '0, golden: '0};
    r.req = '{start_block: srs_pkg::BLOCK_W'(start), length_bytes: srs_pkg::LEN_W'(len)};
    return r;
  endfunction

  // single full segment on disk 0 at buffer offset 0
  function automatic stim_row_t golden_row(input int start, input int len,
                                           input int block, input int bytes);
    stim_row_t r;
    r = req_row(start, len);
    r.kind = ROW_REQ_GOLDEN;
    r.golden = '{disk_index: '0, disk_block: srs_pkg::BLOCK_W'(block),
                 segment_bytes: srs_pkg::LEN_W'(bytes), buffer_offset: '0, last: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [srs_pkg::REGIDX_W-1:0] idx,
                                        input logic [srs_pkg::ADDR_W-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, reg_index: idx, wdata: data, req: '0, golden: '0};
    return r;
  endfunction

  function automatic srs_pkg::in_beat_t random_request();
    srs_pkg::in_beat_t req;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)
      req.start_block = srs_pkg::BLOCK_W'(22'h3FFFFF - $urandom_range(0, 127));
    else if (pick < 30) req.start_block = srs_pkg::BLOCK_W'($urandom_range(0, 255));
    else req.start_block = srs_pkg::BLOCK_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) req.length_bytes = '0;
    else if (pick < 16) req.length_bytes = srs_pkg::LEN_W'($urandom_range(65537, 131071));
    else if (pick < 26) req.length_bytes = srs_pkg::LEN_W'(srs_pkg::MAX_REQUEST_BYTES);
    else if (pick < 56) req.length_bytes = srs_pkg::LEN_W'($urandom_range(1, 4096));
    else req.length_bytes = srs_pkg::LEN_W'($urandom_range(1, 65536));
    return req;
  endfunction

  // first two phases hit the extremes, the rest mostly in range with some clamped values
  task automatic program_phase(input int phase);
    logic [srs_pkg::ADDR_W-1:0] dc, sh, vs;
    dc = $urandom;
    sh = $urandom;
    vs = $urandom;
    if (phase == 0) begin
      dc[srs_pkg::DCOUNT_W-1:0] = 4'd8;
      sh[srs_pkg::SHIFT_W-1:0]  = 5'd11;
      vs = 32'hFFFF_FFFF;
    end else if (phase == 1) begin
      dc[srs_pkg::DCOUNT_W-1:0] = 4'd1;
      sh[srs_pkg::SHIFT_W-1:0]  = 5'd20;
      vs = '0;
    end else begin
      if ($urandom_range(0, 99) < 20)
        dc[srs_pkg::DCOUNT_W-1:0] = ($urandom_range(0, 1) != 0) ? 4'd0
                                                                 : 4'($urandom_range(9, 15));
      else
        dc[srs_pkg::DCOUNT_W-1:0] = 4'($urandom_range(1, 8));
      if ($urandom_range(0, 99) < 15)
        sh[srs_pkg::SHIFT_W-1:0] = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 10))
                                                                : 5'($urandom_range(21, 31));
      else
        sh[srs_pkg::SHIFT_W-1:0] = 5'($urandom_range(11, 20));
      if ($urandom_range(0, 3) == 0) vs = '0;
      else if ($urandom_range(0, 2) == 0) vs = 32'hFFFF_FFFF;
    end
    write_register(srs_pkg::REG_DISK_COUNT, dc);
    write_register(srs_pkg::REG_STRIPE_SHIFT, sh);
    write_register(srs_pkg::REG_VOLUME_START, vs);
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int phase;
    mismatch_count = 0;
    stall_requests = 0;
    tx_idle_pct = 17;
    rx_idle_pct = 54;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;

    // reset values: one disk, 64 KiB stripe, partition at zero
    directed_rows.push_back(golden_row(0, 1, 0, 1));
    directed_rows.push_back(req_row(0, 0));
    directed_rows.push_back(golden_row(0, 65536, 0, 65536));
    directed_rows.push_back(golden_row(22'h3FFFFF, 1, 22'h3FFFFF, 1));
    directed_rows.push_back(golden_row(0, 131071, 0, 65536));
    directed_rows.push_back(req_row(22'h3FFFFF, 65536));
    directed_rows.push_back(req_row(100, 70000));
    // smallest stripe on the most disks: unaligned full request spans the most segments
    directed_rows.push_back(cfg_row(srs_pkg::REG_DISK_COUNT, 32'hFFFF_FFF8));
    directed_rows.push_back(cfg_row(srs_pkg::REG_STRIPE_SHIFT, 32'd11));
    directed_rows.push_back(cfg_row(srs_pkg::REG_VOLUME_START, 32'hFFFF_FFFF));
    directed_rows.push_back(req_row(1, 65536));
    directed_rows.push_back(req_row(22'h3FFFFF, 65536));
    directed_rows.push_back(req_row(0, 0));
    // zero disk count and a too-small shift
    directed_rows.push_back(cfg_row(srs_pkg::REG_DISK_COUNT, 32'd0));
    directed_rows.push_back(cfg_row(srs_pkg::REG_STRIPE_SHIFT, 32'd0));
    directed_rows.push_back(req_row(3, 5000));
    // too many disks and a too-large shift
    directed_rows.push_back(cfg_row(srs_pkg::REG_DISK_COUNT, 32'd15));
    directed_rows.push_back(cfg_row(srs_pkg::REG_STRIPE_SHIFT, 32'd31));
    directed_rows.push_back(cfg_row(srs_pkg::REG_VOLUME_START, 32'h1234_5678));
    directed_rows.push_back(req_row(2047, 65536));
    directed_rows.push_back(req_row(22'h3FFFFE, 3000));
    directed_rows.push_back(cfg_row(srs_pkg::REG_DISK_COUNT, 32'd3));
    directed_rows.push_back(cfg_row(srs_pkg::REG_STRIPE_SHIFT, 32'd20));
    directed_rows.push_back(cfg_row(srs_pkg::REG_VOLUME_START, 32'h0040_0000));
    directed_rows.push_back(req_row(1023, 65535));
    directed_rows.push_back(req_row(5000, 40000));
    directed_rows.push_back(cfg_row(srs_pkg::REG_DISK_COUNT, 32'd5));
    directed_rows.push_back(cfg_row(srs_pkg::REG_STRIPE_SHIFT, 32'd13));
    directed_rows.push_back(cfg_row(srs_pkg::REG_VOLUME_START, 32'h8000_0000));
    directed_rows.push_back(req_row(777, 12345));
    directed_rows.push_back(req_row(0, 65536));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          wait_quiet();
          write_register(directed_rows[i].reg_index, directed_rows[i].wdata);
        end
        ROW_REQ_GOLDEN: send_request(directed_rows[i].req, 1'b1, directed_rows[i].golden);
        default: send_request(directed_rows[i].req, 1'b0, '0);
      endcase
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 3) begin
        tx_idle_pct = 17;
        rx_idle_pct = 54;
      end else if (phase < 6) begin
        tx_idle_pct = 54;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_quiet();
      program_phase(phase);
      // sink goes quiet while requests keep coming, so the input backs up
      if (phase == PRESSURE_PHASE) stall_requests++;
      repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, '0);
    end

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- stripe_request_splitter_top.f -----
+incdir+rtl/core
rtl/core/srs_pkg.sv
rtl/core/srs_chan_if.sv
rtl/core/srs_seq.sv
rtl/core/stripe_request_splitter_top.sv
rtl/core/srs_checker.sv
tb/stripe_request_splitter_top_tb.sv
